/* sv/ifp_pkg.sv */
// Package for the infix to postfix converter.
// Character codes, item classes, queue entry type and precedence and class helpers.
// No dependencies.
`timescale 1ns / 1ps

package ifp_pkg;

  localparam logic [7:0] CH_POW   = 8'h5E; // ^
  localparam logic [7:0] CH_MUL   = 8'h2A; // *
  localparam logic [7:0] CH_DIV   = 8'h2F; // /
  localparam logic [7:0] CH_ADD   = 8'h2B; // +
  localparam logic [7:0] CH_SUB   = 8'h2D; // -
  localparam logic [7:0] CH_OPEN  = 8'h28; // (
  localparam logic [7:0] CH_CLOSE = 8'h29; // )
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;
  localparam logic [7:0] CH_LC_LO  = 8'h61;
  localparam logic [7:0] CH_LC_HI  = 8'h7A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    CL_ALNUM,
    CL_OPEN,
    CL_CLOSE,
    CL_OP,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    cls_t       cls;
    logic [1:0] prec;
    logic       last;
  } entry_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_POW) p = 2'd3;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_ADD || c == CH_SUB) p = 2'd1;
    return p;
  endfunction

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    k = CL_OTHER;
    if ((c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_UC_LO && c <= CH_UC_HI) ||
        (c >= CH_LC_LO && c <= CH_LC_HI))
      k = CL_ALNUM;
    else if (c == CH_OPEN) k = CL_OPEN;
    else if (c == CH_CLOSE) k = CL_CLOSE;
    else if (c == CH_POW || c == CH_MUL || c == CH_DIV || c == CH_ADD || c == CH_SUB)
      k = CL_OP;
    return k;
  endfunction

endpackage

/* sv/infix_to_postfix_converter.sv */
// Top level of the infix to postfix converter (shunting yard).
// Depends on ifp_pkg, ifp_front, ifp_back (and ifp_ram through ifp_back).
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | in_char[7:0], in_expr_end
//   output  | out_valid/out_ready  | out_char[7:0], out_run_last, out_expr_last, out_overflow
//
// In the back end the stack sequencer runs each item through ST_EXEC and then
// ST_FIN; an operator or close parenthesis stays in ST_EXEC while it emits
// operators, and expression end passes through ST_FLUSH to pop the stack. An
// idle back end first loads the item from ST_IDLE.
// Reset clears the stack count and the overflow flag; the stack RAM is not cleared.
// A stalled output holds the back end; the front queue keeps taking up to two items.
`timescale 1ns / 1ps

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_expr_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_expr_last,
  output logic       out_overflow
);

  logic            q_vld;
  logic            q_deq;
  ifp_pkg::entry_t q_head;

  ifp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .in_expr_end (in_expr_end),
    .q_vld       (q_vld),
    .q_head      (q_head),
    .q_deq       (q_deq)
  );

  ifp_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_vld         (q_vld),
    .q_head        (q_head),
    .q_deq         (q_deq),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_run_last  (out_run_last),
    .out_expr_last (out_expr_last),
    .out_overflow  (out_overflow)
  );

endmodule

/* sv/ifp_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/ifp_front.sv */
// Front end: accepts input items, classifies each character and queues it.
// Depends on ifp_pkg.
`timescale 1ns / 1ps

module ifp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char,
  input  logic            in_expr_end,
  output logic            q_vld,
  output ifp_pkg::entry_t q_head,
  input  logic            q_deq
);

  ifp_pkg::entry_t slot_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            pop;
  ifp_pkg::entry_t ent;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_vld    = (cnt_r != 2'd0);
  assign pop      = q_deq && q_vld;
  assign q_head   = slot_r[rp_r];

  always_comb begin
    ent.ch   = in_char;
    ent.cls  = ifp_pkg::classify(in_char);
    ent.prec = ifp_pkg::prec_of(in_char);
    ent.last = in_expr_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= ent;
        wp_r         <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

/* sv/ifp_back.sv */
// Back end: operator stack sequencer, pending result and output register.
// Depends on ifp_pkg and ifp_ram.
`timescale 1ns / 1ps

module ifp_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_vld,
  input  ifp_pkg::entry_t q_head,
  output logic            q_deq,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            out_expr_last,
  output logic            out_overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLUSH,
    ST_FIN
  } state_t;

  state_t          state_r, state_nxt, done_st;
  ifp_pkg::entry_t cur_r;
  logic [CW-1:0]   count_r;
  logic [7:0]      top_r;
  logic            top_vld_r;
  logic            ovf_r;
  logic [7:0]      pend_char_r;
  logic            pend_ovf_r;
  logic            pend_vld_r;
  logic            out_valid_r;
  logic [7:0]      out_char_r;
  logic            out_run_r;
  logic            out_expr_r;
  logic            out_ovf_r;

  logic [7:0]      ram_rdata;
  logic [7:0]      top;
  logic            empty;
  logic            full;
  logic            can_emit;
  logic            can_put;
  logic            do_push;
  logic            do_pop;
  logic            do_put;
  logic [7:0]      put_char;
  logic            fin;
  logic            load;
  logic            out_load;
  logic [CW-1:0]   rd_idx;

  assign top      = top_vld_r ? top_r : ram_rdata;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign can_emit = !out_valid_r || out_ready;
  assign can_put  = !pend_vld_r || can_emit;
  assign done_st  = cur_r.last ? ST_FLUSH : ST_FIN;
  assign rd_idx   = count_r - CW'(2);
  assign q_deq    = load;

  always_comb begin
    state_nxt = state_r;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_put    = 1'b0;
    put_char  = top;
    fin       = 1'b0;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          load      = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cur_r.cls)
          ifp_pkg::CL_ALNUM: begin
            if (can_put) begin
              do_put    = 1'b1;
              put_char  = cur_r.ch;
              state_nxt = done_st;
            end
          end
          ifp_pkg::CL_OPEN: begin
            do_push   = 1'b1;
            state_nxt = done_st;
          end
          ifp_pkg::CL_CLOSE: begin
            if (empty) begin
              state_nxt = done_st;
            end else if (top == ifp_pkg::CH_OPEN) begin
              do_pop    = 1'b1;
              state_nxt = done_st;
            end else if (can_put) begin
              do_put = 1'b1;
              do_pop = 1'b1;
            end
          end
          ifp_pkg::CL_OP: begin
            if (!empty && (ifp_pkg::prec_of(top) >= cur_r.prec)) begin
              if (can_put) begin
                do_put = 1'b1;
                do_pop = 1'b1;
              end
            end else begin
              do_push   = 1'b1;
              state_nxt = done_st;
            end
          end
          default: begin
            state_nxt = done_st;
          end
        endcase
      end
      ST_FLUSH: begin
        if (empty) begin
          state_nxt = ST_FIN;
        end else if (top == ifp_pkg::CH_OPEN) begin
          do_pop = 1'b1;
        end else if (can_put) begin
          do_put = 1'b1;
          do_pop = 1'b1;
        end
      end
      ST_FIN: begin
        if (!((pend_vld_r || cur_r.last) && !can_emit)) begin
          fin = 1'b1;
          if (q_vld) begin
            load      = 1'b1;
            state_nxt = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_load = (do_put && pend_vld_r) || (fin && (pend_vld_r || cur_r.last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      top_vld_r   <= 1'b0;
      ovf_r       <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        cur_r <= q_head;
      end
      // stack
      if (do_push) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r   <= count_r + CW'(1);
          top_r     <= cur_r.ch;
          top_vld_r <= 1'b1;
        end
      end else if (do_pop) begin
        count_r   <= count_r - CW'(1);
        top_vld_r <= 1'b0;
      end
      // pending result and output register
      if (do_put) begin
        if (pend_vld_r) begin
          out_char_r <= pend_char_r;
          out_run_r  <= 1'b0;
          out_expr_r <= 1'b0;
          out_ovf_r  <= pend_ovf_r;
        end
        pend_char_r <= put_char;
        pend_ovf_r  <= ovf_r;
        pend_vld_r  <= 1'b1;
      end else if (fin) begin
        if (pend_vld_r) begin
          out_char_r <= pend_char_r;
          out_run_r  <= 1'b1;
          out_expr_r <= cur_r.last;
          out_ovf_r  <= pend_ovf_r;
          pend_vld_r <= 1'b0;
        end else if (cur_r.last) begin
          out_char_r <= ifp_pkg::CH_NUL;
          out_run_r  <= 1'b1;
          out_expr_r <= 1'b1;
          out_ovf_r  <= ovf_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  ifp_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (do_push && !full),
    .waddr (count_r[IW-1:0]),
    .wdata (cur_r.ch),
    .re    (do_pop),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_run_last  = out_run_r;
  assign out_expr_last = out_expr_r;
  assign out_overflow  = out_ovf_r;

endmodule

/* tb/infix_to_postfix_converter_tb.sv */
// Testbench for infix_to_postfix_converter: a directed table, then random
// expressions and noise, checked against an operator-stack predictor.
// Depends on ifp_pkg and the converter RTL only.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

  localparam int STACK_DEPTH = 32;
  localparam int N_RAND      = 130;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_ONE
  } row_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       expr_last;
    logic       ovf;
  } postfix_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    row_kind_t  kind;
    logic [7:0] ech;
    logic       erun;
    logic       eend;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       in_expr_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_expr_last;
  logic       out_overflow;

  // predictor state
  logic [7:0]   op_stk [STACK_DEPTH];
  int           stk_n;
  logic         ovf_seen;
  postfix_res_t step_res[$];
  postfix_res_t postfix_q[$];
  postfix_res_t want_res;

  dir_row_t   dir_tab [25];
  char_item_t gen_q[$];

  int n_mismatch = 0;
  int n_results  = 0;
  int n_items    = 0;
  int n_exprs    = 0;
  int n_gen      = 0;
  bit in_calm    = 1'b0;
  bit out_calm   = 1'b0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_expr_end  (in_expr_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_expr_last(out_expr_last),
    .out_overflow (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still expected", postfix_q.size());
    $display("infix_to_postfix_converter_tb NOT OK");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic int rank_of(input logic [7:0] c);
    case (c)
      ifp_pkg::CH_POW:                  return 3;
      ifp_pkg::CH_MUL, ifp_pkg::CH_DIV: return 2;
      ifp_pkg::CH_ADD, ifp_pkg::CH_SUB: return 1;
      default:                          return 0;
    endcase
  endfunction

  function automatic void emit(input logic [7:0] c);
    step_res.push_back('{c, 1'b0, 1'b0, ovf_seen});
  endfunction

  function automatic void stack_push(input logic [7:0] c);
    if (stk_n >= STACK_DEPTH) begin
      ovf_seen = 1'b1;
    end else begin
      op_stk[stk_n] = c;
      stk_n++;
    end
  endfunction

  function automatic void predict_postfix(input logic [7:0] c, input logic e);
    step_res = {};
    if ((c >= ifp_pkg::CH_DIG_LO && c <= ifp_pkg::CH_DIG_HI) ||
        (c >= ifp_pkg::CH_UC_LO && c <= ifp_pkg::CH_UC_HI) ||
        (c >= ifp_pkg::CH_LC_LO && c <= ifp_pkg::CH_LC_HI)) begin
      emit(c);
    end else if (c == ifp_pkg::CH_OPEN) begin
      stack_push(c);
    end else if (c == ifp_pkg::CH_CLOSE) begin
      while (stk_n > 0 && op_stk[stk_n - 1] != ifp_pkg::CH_OPEN) begin
        stk_n--;
        emit(op_stk[stk_n]);
      end
      if (stk_n > 0) stk_n--;
    end else if (c == ifp_pkg::CH_POW || c == ifp_pkg::CH_MUL || c == ifp_pkg::CH_DIV ||
                 c == ifp_pkg::CH_ADD || c == ifp_pkg::CH_SUB) begin
      while (stk_n > 0 && rank_of(op_stk[stk_n - 1]) >= rank_of(c)) begin
        stk_n--;
        emit(op_stk[stk_n]);
      end
      stack_push(c);
    end
    if (e) begin
      // flush; stray open parens are dropped silently
      while (stk_n > 0) begin
        stk_n--;
        if (op_stk[stk_n] != ifp_pkg::CH_OPEN) emit(op_stk[stk_n]);
      end
      if (step_res.size() == 0) emit(ifp_pkg::CH_NUL);
      step_res[step_res.size() - 1].expr_last = 1'b1;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
  endfunction

  // ---------------- stimulus generation ----------------

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return ifp_pkg::CH_DIG_LO + 8'($urandom_range(0, 9));
      1:       return ifp_pkg::CH_UC_LO + 8'($urandom_range(0, 25));
      default: return ifp_pkg::CH_LC_LO + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return ifp_pkg::CH_POW;
      1:       return ifp_pkg::CH_MUL;
      2:       return ifp_pkg::CH_DIV;
      3:       return ifp_pkg::CH_ADD;
      default: return ifp_pkg::CH_SUB;
    endcase
  endfunction

  function automatic void add_char(input logic [7:0] c);
    gen_q.push_back('{c, 1'b0});
    n_gen++;
  endfunction

  function automatic void gen_expr(input int lvl);
    int nterms;
    nterms = $urandom_range(1, 4);
    for (int i = 0; i < nterms; i++) begin
      if (i > 0) add_char(rand_operator());
      if (lvl < 3 && $urandom_range(0, 3) == 0) begin
        add_char(ifp_pkg::CH_OPEN);
        gen_expr(lvl + 1);
        add_char(ifp_pkg::CH_CLOSE);
      end else begin
        add_char(rand_operand());
      end
    end
  endfunction

  function automatic void gen_unit();
    int len;
    gen_q = {};
    case ($urandom_range(0, 7))
      0: begin
        // raw byte, counted only when it closes an expression
        gen_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
        if ($urandom_range(0, 5) == 0) begin
          gen_q[0].fin = 1'b1;
          n_gen++;
        end
      end
      1: begin
        // broken sequence: stray parens and operators
        len = $urandom_range(1, 8);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       add_char(rand_operand());
            1:       add_char(rand_operator());
            2:       add_char(ifp_pkg::CH_OPEN);
            default: add_char(ifp_pkg::CH_CLOSE);
          endcase
        end
        gen_q[gen_q.size() - 1].fin = 1'($urandom_range(0, 1));
      end
      default: begin
        gen_expr(0);
        gen_q[gen_q.size() - 1].fin = 1'b1;
      end
    endcase
  endfunction

  // ---------------- drivers and checker ----------------

  task automatic drive_char(input logic [7:0] c, input logic e, input row_kind_t kind,
                            input postfix_res_t tres);
    int gap;
    if ($urandom_range(0, 24) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_char     <= c;
    in_expr_end <= e;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_postfix(c, e);
    case (kind)
      ROW_PRED: foreach (step_res[j]) postfix_q.push_back(step_res[j]);
      ROW_ONE:  postfix_q.push_back(tres);
      default: ;
    endcase
    n_items++;
    if (e) n_exprs++;
    @(negedge clk);
  endtask

  task automatic drive_queue();
    foreach (gen_q[i]) drive_char(gen_q[i].ch, gen_q[i].fin, ROW_PRED, '0);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
    n_mismatch++;
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 24) == 0) out_calm = !out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      n_results++;
      if (postfix_q.size() == 0) begin
        report_mismatch("unexpected item, out_char", out_char, 8'h00);
      end else begin
        want_res = postfix_q.pop_front();
        if (out_char !== want_res.ch)
          report_mismatch("out_char", out_char, want_res.ch);
        if (out_run_last !== want_res.run_last)
          report_mismatch("out_run_last", 8'(out_run_last), 8'(want_res.run_last));
        if (out_expr_last !== want_res.expr_last)
          report_mismatch("out_expr_last", 8'(out_expr_last), 8'(want_res.expr_last));
        if (out_overflow !== want_res.ovf)
          report_mismatch("out_overflow", 8'(out_overflow), 8'(want_res.ovf));
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_char     = ifp_pkg::CH_NUL;
    in_expr_end = 1'b0;
    stk_n       = 0;
    ovf_seen    = 1'b0;

    dir_tab = '{
      // empty end gives terminator
      '{ifp_pkg::CH_NUL,    1'b1, ROW_ONE,  ifp_pkg::CH_NUL,    1'b1, 1'b1},
      '{ifp_pkg::CH_LC_LO,  1'b0, ROW_ONE,  ifp_pkg::CH_LC_LO,  1'b1, 1'b0},
      '{ifp_pkg::CH_LC_HI,  1'b1, ROW_ONE,  ifp_pkg::CH_LC_HI,  1'b1, 1'b1},
      '{ifp_pkg::CH_DIG_LO, 1'b0, ROW_ONE,  ifp_pkg::CH_DIG_LO, 1'b1, 1'b0},
      '{ifp_pkg::CH_DIG_HI, 1'b0, ROW_ONE,  ifp_pkg::CH_DIG_HI, 1'b1, 1'b0},
      '{ifp_pkg::CH_UC_LO,  1'b0, ROW_ONE,  ifp_pkg::CH_UC_LO,  1'b1, 1'b0},
      '{ifp_pkg::CH_UC_HI,  1'b0, ROW_ONE,  ifp_pkg::CH_UC_HI,  1'b1, 1'b0},
      // ignored bytes
      '{8'hFF,              1'b0, ROW_NONE, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{8'h40,              1'b0, ROW_NONE, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{8'h7B,              1'b1, ROW_ONE,  ifp_pkg::CH_NUL,    1'b1, 1'b1},
      // close on empty stack
      '{ifp_pkg::CH_CLOSE,  1'b0, ROW_NONE, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_OPEN,   1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_LC_LO,  1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_ADD,    1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{8'h62,              1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_CLOSE,  1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_MUL,    1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{8'h63,              1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_POW,    1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{8'h64,              1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      // left-assoc power
      '{ifp_pkg::CH_POW,    1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{8'h65,              1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_SUB,    1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      '{ifp_pkg::CH_DIV,    1'b0, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0},
      // open paren left at end
      '{ifp_pkg::CH_OPEN,   1'b1, ROW_PRED, ifp_pkg::CH_NUL,    1'b0, 1'b0}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      drive_char(dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].kind,
                 '{dir_tab[i].ech, dir_tab[i].erun, dir_tab[i].eend, 1'b0});

    while (n_gen < N_RAND) begin
      gen_unit();
      drive_queue();
    end

    // deep stack, long flush in one step
    gen_q = {};
    repeat (7) begin
      add_char(ifp_pkg::CH_ADD);
      add_char(ifp_pkg::CH_MUL);
      add_char(ifp_pkg::CH_POW);
      add_char(ifp_pkg::CH_OPEN);
    end
    gen_q.push_back('{8'h77, 1'b1});
    drive_queue();

    // fill the stack past its depth; overflow stays set from here on
    gen_q = {};
    repeat (STACK_DEPTH + 2) add_char(ifp_pkg::CH_OPEN);
    add_char(8'h71);
    add_char(ifp_pkg::CH_CLOSE);
    add_char(ifp_pkg::CH_ADD);
    gen_q.push_back('{8'h72, 1'b1});
    drive_queue();

    repeat (4) begin
      gen_unit();
      drive_queue();
    end

    in_valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d characters in %0d expressions sent, %0d postfix items checked",
             n_items, n_exprs, n_results);
    $display("covered ignored bytes, stray parens, deep flush and stack overflow");
    if (n_mismatch == 0) begin
      $display("infix_to_postfix_converter_tb OK");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("infix_to_postfix_converter_tb NOT OK");
    end
    $finish;
  end

endmodule
